### design/msfl_pkg.sv
// Package: request and result types, status and command codes, default sizes.
`timescale 1ns / 1ps
package msfl_pkg;

  localparam int SLOT_COUNT_DEF  = 128;
  localparam int STACK_COUNT_DEF = 8;
  localparam int IDX_W           = 3;
  localparam int VAL_W           = 32;
  localparam int CFG_W           = 4;
  localparam logic [CFG_W-1:0] STACKS_RESET = 4'd8;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef struct packed {
    logic                    command;
    logic [IDX_W-1:0]        stack_index;
    logic signed [VAL_W-1:0] push_value;
  } msfl_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pop_value;
    status_e                 status;
  } msfl_rsp_t;

endpackage

### design/msfl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module msfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/msfl_link.sv
// Link store: RAM plus a high-water mark that supplies the reset chain for untouched slots.
`timescale 1ns / 1ps
module msfl_link #(
  parameter int SLOT_COUNT = msfl_pkg::SLOT_COUNT_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          rd_en_i,
  input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_addr_i,
  output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1):0]   rd_link_o,
  input  logic                                          wr_en_i,
  input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] wr_addr_i,
  input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1):0]   wr_link_i
);
  import msfl_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  logic [SLOT_W:0]   hwm_q, hwm_d;
  logic              fresh_q;
  logic [SLOT_W-1:0] raddr_q;
  logic [SLOT_W:0]   ram_link;
  logic [SLOT_W:0]   init_link;

  msfl_ram #(
    .WIDTH(SLOT_W + 1),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_link_i),
    .re_i   (rd_en_i),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_link)
  );

  always_comb begin
    hwm_d = hwm_q;
    if (wr_en_i && ({1'b0, wr_addr_i} == hwm_q)) begin
      hwm_d = hwm_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hwm_q   <= '0;
      fresh_q <= 1'b0;
    end else begin
      hwm_q <= hwm_d;
      if (rd_en_i) begin
        fresh_q <= ({1'b0, rd_addr_i} >= hwm_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      raddr_q <= rd_addr_i;
    end
  end

  assign init_link = {(raddr_q != LAST_SLOT), raddr_q + SLOT_W'(1)};
  assign rd_link_o = fresh_q ? init_link : ram_link;

endmodule

### design/multi_stack_free_list.sv
// Top level: several linked stacks sharing one slot store with a free list.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (msfl_req_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (msfl_rsp_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (stacks_in_use)
//
// Each request is handled in a read step and a write-back step: the link and value
// memories are read as it is accepted; then the links, top pointer and free head are
// written back and the result register is loaded. The registered link read forces this split.
// Reset takes effect at once; untouched slots follow the reset chain via a
// high-water mark, so no clearing pass is needed.
// A result held on out stalls the write-back cycle until it is taken.
`timescale 1ns / 1ps
module multi_stack_free_list #(
  parameter int SLOT_COUNT  = msfl_pkg::SLOT_COUNT_DEF,
  parameter int STACK_COUNT = msfl_pkg::STACK_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  msfl_pkg::msfl_req_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output msfl_pkg::msfl_rsp_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [msfl_pkg::CFG_W-1:0]   cfg_data_i
);
  import msfl_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TOP_N  = (STACK_COUNT < (1 << IDX_W)) ? STACK_COUNT : (1 << IDX_W);
  localparam int TOP_W  = (TOP_N > 1) ? $clog2(TOP_N) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_q, state_d;
  logic [CFG_W-1:0]  stacks_q;
  logic [SLOT_W:0]   free_q;
  logic [SLOT_W:0]   tops_q [TOP_N];
  logic              cmd_q;
  logic [TOP_W-1:0]  k_q;
  logic [VAL_W-1:0]  data_q;
  logic [SLOT_W-1:0] slot_q;
  status_e           stat_q;
  logic              out_valid_q;
  msfl_rsp_t         out_q;

  logic              in_fire, done, commit;
  logic [TOP_W-1:0]  k_in;
  logic [SLOT_W:0]   top_in;
  logic              bad_idx;
  status_e           stat_in;
  logic [SLOT_W:0]   link_rd;
  logic [VAL_W-1:0]  value_rd;
  logic              link_we;
  logic [SLOT_W:0]   link_wd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign done        = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign commit      = done && (stat_q == ST_OK);

  assign k_in    = in_data_i.stack_index[TOP_W-1:0];
  assign top_in  = tops_q[k_in];
  assign bad_idx = ({1'b0, in_data_i.stack_index} >= stacks_q)
                || (32'(in_data_i.stack_index) >= STACK_COUNT);

  always_comb begin
    if (bad_idx) begin
      stat_in = ST_INVALID;
    end else if (in_data_i.command == CMD_PUSH) begin
      stat_in = free_q[SLOT_W] ? ST_OK : ST_OVERFLOW;
    end else begin
      stat_in = top_in[SLOT_W] ? ST_OK : ST_UNDERFLOW;
    end
  end

  msfl_link #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_link (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire && (stat_in == ST_OK)),
    .rd_addr_i((in_data_i.command == CMD_PUSH) ? free_q[SLOT_W-1:0] : top_in[SLOT_W-1:0]),
    .rd_link_o(link_rd),
    .wr_en_i  (link_we),
    .wr_addr_i(slot_q),
    .wr_link_i(link_wd)
  );

  msfl_ram #(
    .WIDTH(VAL_W),
    .DEPTH(SLOT_COUNT)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (commit && (cmd_q == CMD_PUSH)),
    .waddr_i(slot_q),
    .wdata_i(data_q),
    .re_i   (in_fire && (stat_in == ST_OK) && (in_data_i.command == CMD_POP)),
    .raddr_i(top_in[SLOT_W-1:0]),
    .rdata_o(value_rd)
  );

  assign link_we = commit;
  assign link_wd = (cmd_q == CMD_PUSH) ? tops_q[k_q] : free_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stacks_q    <= STACKS_RESET;
      free_q      <= {1'b1, {SLOT_W{1'b0}}};
      out_valid_q <= 1'b0;
      for (int i = 0; i < TOP_N; i++) begin
        tops_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        stacks_q <= cfg_data_i;
      end
      if (commit) begin
        if (cmd_q == CMD_PUSH) begin
          free_q      <= link_rd;
          tops_q[k_q] <= {1'b1, slot_q};
        end else begin
          free_q      <= {1'b1, slot_q};
          tops_q[k_q] <= link_rd;
        end
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_data_i.command;
      k_q    <= k_in;
      data_q <= in_data_i.push_value;
      slot_q <= (in_data_i.command == CMD_PUSH) ? free_q[SLOT_W-1:0] : top_in[SLOT_W-1:0];
      stat_q <= stat_in;
    end
    if (done) begin
      out_q.status    <= stat_q;
      out_q.pop_value <= (commit && (cmd_q == CMD_POP)) ? value_rd : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.pop_value == '0)
    else $error("failed request carries nonzero pop value");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o && !done || (state_q == S_EXEC))
    else $error("request accepted while another is in flight");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (cmd_q == CMD_POP) |=> free_q[SLOT_W] && (free_q[SLOT_W-1:0] == $past(slot_q)))
    else $error("popped slot not returned to free list");

  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (cmd_q == CMD_PUSH) |=> tops_q[$past(k_q)] == {1'b1, $past(slot_q)})
    else $error("pushed slot not placed on stack top");

endmodule
